### rtl/core/tkch_pkg.sv
// Shared types and constants for the two-key click/hold detector.
// No dependencies; imported by every module of the block.
package tkch_pkg;

   // Width of the press, release and repeat time counters.
   localparam int TimeWidth = 16;
   localparam int CfgWidth  = 16;
   localparam int MsWidth   = 8;
   localparam int KeyWidth  = 2;
   localparam int EventWidth = 4;

   localparam int ReqDataWidth = 16;
   localparam int RspDataWidth = 8;
   localparam int CsrIndexWidth = 2;

   // Register indexes of the configuration port.
   localparam logic [CsrIndexWidth-1:0] CsrClickDebounce = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrHold          = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CsrRelease       = 2'd2;

   localparam logic [CfgWidth-1:0] ClickDebounceReset = 16'd30;
   localparam logic [CfgWidth-1:0] HoldReset          = 16'd1000;
   localparam logic [CfgWidth-1:0] ReleaseReset       = 16'd50;

   localparam logic [KeyWidth-1:0] KeysNone = 2'b00;
   localparam logic [KeyWidth-1:0] KeysBoth = 2'b11;

   // Event codes: the base is added to the pressed-key code (1 up, 2 down, 3 both).
   localparam logic [EventWidth-1:0] EvIdle  = 4'd0;
   localparam logic [EventWidth-1:0] EvClick = 4'd0;
   localparam logic [EventWidth-1:0] EvEnter = 4'd3;
   localparam logic [EventWidth-1:0] EvCont  = 4'd6;

   typedef struct packed {
      logic [CfgWidth-1:0] click_debounce_ms;
      logic [CfgWidth-1:0] hold_ms;
      logic [CfgWidth-1:0] release_ms;
   } cfg_type;

endpackage

### rtl/core/tkch_csr.sv
// Configuration register file of the two-key click/hold detector.
// Depends on tkch_pkg for the register indexes, reset values and cfg_type.
module tkch_csr import tkch_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CfgWidth-1:0]      csr_data,
   output cfg_type                  cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CsrClickDebounce: cfg_in.click_debounce_ms = csr_data;
            CsrHold:          cfg_in.hold_ms           = csr_data;
            CsrRelease:       cfg_in.release_ms        = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.click_debounce_ms <= ClickDebounceReset;
         cfg_ff.hold_ms           <= HoldReset;
         cfg_ff.release_ms        <= ReleaseReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### rtl/core/tkch_fsm.sv
// Idle/debounce/hold state machine with its time counters.
// Depends on tkch_pkg; advances one tick whenever step is high.
module tkch_fsm import tkch_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic [KeyWidth-1:0]   key_lines,
   input  logic [MsWidth-1:0]    elapsed_ms,
   input  cfg_type               cfg,
   output logic [EventWidth-1:0] key_event
);

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_DEBOUNCE = 2'd1,
      PH_HOLD     = 2'd2
   } phase_type;

   localparam logic [TimeWidth-1:0] TimeMax = '1;

   phase_type             phase_ff, phase_in;
   logic [KeyWidth-1:0]   held_ff, held_in;
   logic [TimeWidth-1:0]  stable_ff, stable_in;
   logic [TimeWidth-1:0]  repeat_ff, repeat_in;

   logic [KeyWidth-1:0]   keys;
   logic [TimeWidth:0]    stable_sum, repeat_sum;
   logic [TimeWidth-1:0]  stable_sat, repeat_sat;
   logic [TimeWidth-1:0]  click_t, hold_t, release_t;
   logic [EventWidth-1:0] held_code;

   assign keys = ~key_lines;

   assign stable_sum = {1'b0, stable_ff} + (TimeWidth+1)'(elapsed_ms);
   assign repeat_sum = {1'b0, repeat_ff} + (TimeWidth+1)'(elapsed_ms);
   assign stable_sat = stable_sum[TimeWidth] ? TimeMax : stable_sum[TimeWidth-1:0];
   assign repeat_sat = repeat_sum[TimeWidth] ? TimeMax : repeat_sum[TimeWidth-1:0];

   assign click_t   = TimeWidth'(cfg.click_debounce_ms);
   assign hold_t    = TimeWidth'(cfg.hold_ms);
   assign release_t = TimeWidth'(cfg.release_ms);
   assign held_code = EventWidth'(held_ff);

   always_comb begin
      phase_in  = phase_ff;
      held_in   = held_ff;
      stable_in = stable_ff;
      repeat_in = repeat_ff;
      key_event = EvIdle;
      if (elapsed_ms != '0) begin
         unique case (phase_ff)
            PH_DEBOUNCE: begin
               if (keys == held_ff) begin
                  stable_in = stable_sat;
                  if (stable_sat >= hold_t) begin
                     phase_in  = PH_HOLD;
                     stable_in = '0;
                     if (held_ff != KeysNone) key_event = EvEnter + held_code;
                  end
               end else if (keys == KeysNone) begin
                  if (stable_ff >= click_t && held_ff != KeysNone) begin
                     key_event = EvClick + held_code;
                  end
                  phase_in  = PH_IDLE;
                  stable_in = '0;
               end else if (held_ff != KeysBoth && keys == KeysBoth) begin
                  held_in   = KeysBoth;
                  stable_in = '0;
               end else if (held_ff == KeysBoth) begin
                  // One key left a two-key press: a long enough press counts as a click.
                  if (stable_ff >= click_t) begin
                     key_event = EvClick + EventWidth'(KeysBoth);
                     phase_in  = PH_HOLD;
                  end else begin
                     held_in = keys;
                  end
                  stable_in = '0;
               end else begin
                  held_in   = keys;
                  stable_in = '0;
               end
            end
            PH_HOLD: begin
               if (keys == KeysNone) begin
                  stable_in = stable_sat;
                  if (stable_sat >= release_t) begin
                     phase_in  = PH_IDLE;
                     stable_in = '0;
                  end
               end else begin
                  stable_in = '0;
                  repeat_in = repeat_sat;
                  if (repeat_sat >= hold_t) begin
                     if (held_ff != KeysNone) key_event = EvCont + held_code;
                     repeat_in = '0;
                  end
               end
            end
            default: begin
               // The unused phase code behaves as idle.
               if (keys != KeysNone) begin
                  stable_in = '0;
                  phase_in  = PH_DEBOUNCE;
                  held_in   = keys;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         held_ff   <= KeysNone;
         stable_ff <= '0;
         repeat_ff <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         held_ff   <= held_in;
         stable_ff <= stable_in;
         repeat_ff <= repeat_in;
      end
   end

endmodule

### rtl/core/two_key_click_hold_detector_core.sv
// Top level of the two-key click/hold detector: request and response stages
// around the state machine. Depends on tkch_pkg, tkch_csr and tkch_fsm.
//
// Usage:
// Each request on req_ carries one tick: the two active-low key lines and
// the milliseconds elapsed since the previous tick. Every request yields
// exactly one response on rsp_ carrying the key event code (0 idle, 1..3
// click, 4..6 hold entry, 7..9 hold repeat for up, down and both keys).
// A request is registered at the input stage and evaluated against the state
// once the response register is free or draining; its event is then
// registered in the response register, which raises rsp_tvalid. One request
// is taken every cycle while rsp_tready stays high; the only work per tick is
// one saturating add and compare.
// When rsp_tready is low the response register holds and the input stage
// keeps at most one further request, after which req_tready drops.
// Configuration registers are written on the csr_ port, which is always
// ready; write them only while no request is in flight.
// Reset (synchronous, active high) empties both stages, returns the state
// machine to idle with cleared counters and restores the register defaults.
module two_key_click_hold_detector_core import tkch_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [ReqDataWidth-1:0]  req_tdata,  // key_lines[1:0], elapsed_ms[9:2]
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RspDataWidth-1:0]  rsp_tdata,  // key_event[3:0]
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CfgWidth-1:0]      csr_data
);

   cfg_type cfg;

   logic                  in_valid_ff, in_valid_in;
   logic [KeyWidth-1:0]   in_keys_ff;
   logic [MsWidth-1:0]    in_ms_ff;
   logic                  out_valid_ff, out_valid_in;
   logic [EventWidth-1:0] out_event_ff;
   logic [EventWidth-1:0] fsm_event;
   logic                  advance;
   logic                  req_take;

   tkch_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // The held request moves on when the response register is free or draining.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take = req_tvalid && req_tready;

   tkch_fsm u_fsm (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .key_lines  (in_keys_ff),
      .elapsed_ms (in_ms_ff),
      .cfg        (cfg),
      .key_event  (fsm_event)
   );

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_keys_ff <= req_tdata[KeyWidth-1:0];
         in_ms_ff   <= req_tdata[KeyWidth+MsWidth-1:KeyWidth];
      end
      if (advance) begin
         out_event_ff <= fsm_event;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RspDataWidth-EventWidth){1'b0}}, out_event_ff};

endmodule

### tb/two_key_click_hold_detector_core_tb.sv
// Testbench for two_key_click_hold_detector_core: drives key ticks, writes the
// timing registers between phases and checks every key event against a predictor.
// Depends on tkch_pkg and the detector RTL only.
`timescale 1ns / 1ps

module two_key_click_hold_detector_core_tb;
   import tkch_pkg::*;

   typedef enum logic [1:0] {
      PhaseIdle,
      PhaseDebounce,
      PhaseHold,
      PhaseSpare
   } detect_phase_type;

   // Tracks the detector state and keeps the key events still to come.
   class key_event_scoreboard;
      logic [CfgWidth-1:0]   debounce_limit;
      logic [CfgWidth-1:0]   hold_limit;
      logic [CfgWidth-1:0]   release_limit;
      detect_phase_type      phase;
      logic [KeyWidth-1:0]   pressed;
      logic [TimeWidth-1:0]  press_time;
      logic [TimeWidth-1:0]  repeat_acc;
      logic [EventWidth-1:0] pending_events[$];
      int                    errors;

      function new();
         debounce_limit = ClickDebounceReset;
         hold_limit     = HoldReset;
         release_limit  = ReleaseReset;
         phase          = PhaseIdle;
         pressed        = KeysNone;
         press_time     = '0;
         repeat_acc     = '0;
         errors         = 0;
      endfunction

      function void set_limits(logic [CfgWidth-1:0] debounce, logic [CfgWidth-1:0] hold,
                               logic [CfgWidth-1:0] rel);
         debounce_limit = debounce;
         hold_limit     = hold;
         release_limit  = rel;
      endfunction

      function logic [TimeWidth-1:0] add_clamped(logic [TimeWidth-1:0] acc,
                                                  logic [MsWidth-1:0] ms);
         logic [TimeWidth:0] sum;
         sum = {1'b0, acc} + (TimeWidth+1)'(ms);
         return sum[TimeWidth] ? {TimeWidth{1'b1}} : sum[TimeWidth-1:0];
      endfunction

      function logic [EventWidth-1:0] event_code(logic [EventWidth-1:0] base);
         if (pressed == KeysNone) return EvIdle;
         return base + EventWidth'(pressed);
      endfunction

      function void note_tick(logic [KeyWidth-1:0] lines, logic [MsWidth-1:0] ms);
         logic [KeyWidth-1:0]   down;
         logic [EventWidth-1:0] ev;
         down = ~lines;
         ev = EvIdle;
         if (ms != 0) begin
            case (phase)
               PhaseDebounce: begin
                  if (down == pressed) begin
                     press_time = add_clamped(press_time, ms);
                     if (press_time >= hold_limit) begin
                        phase = PhaseHold;
                        press_time = '0;
                        ev = event_code(EvEnter);
                     end
                  end else if (down == KeysNone) begin
                     if (press_time >= debounce_limit) ev = event_code(EvClick);
                     phase = PhaseIdle;
                     press_time = '0;
                  end else if (pressed != KeysBoth && down == KeysBoth) begin
                     pressed = KeysBoth;
                     press_time = '0;
                  end else if (pressed == KeysBoth) begin
                     // Dropping one of two keys after debounce still counts as a both click.
                     if (press_time >= debounce_limit) begin
                        ev = EvClick + EventWidth'(KeysBoth);
                        phase = PhaseHold;
                     end else begin
                        pressed = down;
                     end
                     press_time = '0;
                  end else begin
                     pressed = down;
                     press_time = '0;
                  end
               end
               PhaseHold: begin
                  if (down == KeysNone) begin
                     press_time = add_clamped(press_time, ms);
                     if (press_time >= release_limit) begin
                        phase = PhaseIdle;
                        press_time = '0;
                     end
                  end else begin
                     press_time = '0;
                     repeat_acc = add_clamped(repeat_acc, ms);
                     if (repeat_acc >= hold_limit) begin
                        ev = event_code(EvCont);
                        repeat_acc = '0;
                     end
                  end
               end
               default: begin
                  if (down != KeysNone) begin
                     press_time = '0;
                     phase = PhaseDebounce;
                     pressed = down;
                  end
               end
            endcase
         end
         pending_events.push_back(ev);
      endfunction

      function void check_event(logic [EventWidth-1:0] got);
         logic [EventWidth-1:0] want;
         if (pending_events.size() == 0) begin
            $error("key_event: response with no request pending, actual %0d", got);
            errors++;
         end else begin
            want = pending_events.pop_front();
            if (got !== want) begin
               $error("key_event: expected %0d, actual %0d", want, got);
               errors++;
            end
         end
      endfunction

      function int outstanding();
         return pending_events.size();
      endfunction

      function bit all_clear();
         if (pending_events.size() != 0) begin
            $error("key_event: %0d responses never arrived", pending_events.size());
            errors++;
         end
         return errors == 0;
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [ReqDataWidth-1:0]  req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RspDataWidth-1:0]  rsp_tdata;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CfgWidth-1:0]      csr_data = '0;

   key_event_scoreboard sb;
   bit no_idle = 1'b0;
   int live_ticks = 0;
   int quiet_cycles = 0;

   two_key_click_hold_detector_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_tick(req_tdata[1:0], req_tdata[9:2]);
         if (rsp_tvalid && rsp_tready) sb.check_event(rsp_tdata[EventWidth-1:0]);
      end
   end

   // Any accepted request, response or register write restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= 2000) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Response side: random stalls, plus one long stall that backs up the input.
   initial begin
      int taken;
      bit long_done;
      taken = 0;
      long_done = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) taken++;
         if (!long_done && taken >= 120) begin
            long_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (60) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (!no_idle && $urandom_range(0, 6) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic send_tick(input logic [KeyWidth-1:0] lines, input logic [MsWidth-1:0] ms);
      if (!no_idle && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(ReqDataWidth - MsWidth - KeyWidth){1'b0}}, ms, lines};
      do @(posedge clock); while (!req_tready);
      if (ms != 0) live_ticks++;
   endtask

   function automatic logic [MsWidth-1:0] pick_ms();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return MsWidth'($urandom_range(128, 255));
         default: return MsWidth'($urandom_range(1, 40));
      endcase
   endfunction

   // Mostly a press of random keys with the odd change of keys, then a release;
   // now and then a short burst of arbitrary ticks.
   task automatic send_gesture();
      logic [KeyWidth-1:0] down;
      int press_len;
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 4)) send_tick(KeyWidth'($urandom_range(0, 3)), pick_ms());
      end else begin
         down = KeyWidth'($urandom_range(1, 3));
         press_len = $urandom_range(1, 14);
         for (int i = 0; i < press_len; i++) begin
            if ($urandom_range(0, 7) == 0) down = KeyWidth'($urandom_range(1, 3));
            send_tick(~down, pick_ms());
         end
         repeat ($urandom_range(1, 6)) send_tick(~KeysNone, pick_ms());
      end
   endtask

   task automatic run_gestures(input int count);
      int start;
      start = live_ticks;
      while (live_ticks - start < count) send_gesture();
   endtask

   // Waits for a clock edge before checking, so the request accepted at the last edge is already counted.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_reg(input logic [CsrIndexWidth-1:0] idx, input logic [CfgWidth-1:0] val);
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_config(input logic [CfgWidth-1:0] debounce,
                               input logic [CfgWidth-1:0] hold,
                               input logic [CfgWidth-1:0] rel);
      csr_valid <= 1'b1;
      put_reg(CsrClickDebounce, debounce);
      put_reg(CsrHold, hold);
      put_reg(CsrRelease, rel);
      csr_valid <= 1'b0;
      sb.set_limits(debounce, hold, rel);
   endtask

   task automatic write_random_config();
      write_config(CfgWidth'($urandom_range(0, 80)), CfgWidth'($urandom_range(20, 300)),
                   CfgWidth'($urandom_range(0, 80)));
   endtask

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed ticks at the register defaults. A tick with no elapsed time
      // must change nothing even with both keys down.
      send_tick(2'b00, 8'd0);
      // Up key held past the click debounce, then released: up click.
      send_tick(2'b10, 8'd10);
      send_tick(2'b10, 8'd20);
      send_tick(2'b10, 8'd15);
      send_tick(2'b11, 8'd5);
      // Down key released before the debounce time: no event.
      send_tick(2'b01, 8'd255);
      send_tick(2'b01, 8'd10);
      send_tick(2'b11, 8'd3);
      // Down joins up, then one key leaves after debounce: both click into hold.
      send_tick(2'b10, 8'd1);
      send_tick(2'b00, 8'd5);
      send_tick(2'b00, 8'd40);
      send_tick(2'b01, 8'd3);
      send_tick(2'b01, 8'd200);
      send_tick(2'b11, 8'd255);
      // Single keys swap, too short for a click.
      send_tick(2'b10, 8'd7);
      send_tick(2'b01, 8'd7);
      send_tick(2'b01, 8'd8);
      send_tick(2'b11, 8'd2);
      // Both keys, one leaves early, the other is held into hold entry.
      send_tick(2'b00, 8'd4);
      send_tick(2'b00, 8'd10);
      send_tick(2'b10, 8'd2);
      repeat (4) send_tick(2'b10, 8'd255);
      drain();

      write_config('0, 16'd1, '0);
      run_gestures(20);
      drain();

      repeat (2) begin
         write_random_config();
         run_gestures(25);
         drain();
      end

      // Largest hold limit: the press time reaches hold entry only by saturating,
      // then a zero release time ends the hold at once.
      write_config(16'hFFFF, 16'hFFFF, '0);
      send_tick(2'b00, 8'd100);
      send_tick(2'b00, 8'd100);
      repeat (258) send_tick(2'b00, 8'd255);
      send_tick(2'b11, 8'd1);
      drain();

      no_idle = 1'b1;
      write_random_config();
      run_gestures(30);
      drain();

      repeat (10) @(posedge clock);
      if (sb.all_clear()) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/tkch_pkg.sv
rtl/core/tkch_csr.sv
rtl/core/tkch_fsm.sv
rtl/core/two_key_click_hold_detector_core.sv
tb/two_key_click_hold_detector_core_tb.sv
